FILE: design/rwsb_pkg.sv
// Shared types and codes for the reorder window / SACK builder.
// Used by rwsb_front, rwsb_back and the top level; no dependencies.
`default_nettype none
package rwsb_pkg;

  localparam logic [1:0] OP_MSG  = 2'd0;
  localparam logic [1:0] OP_DLV  = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;
  localparam logic [1:0] OP_DROP = 2'd3;

  localparam logic [3:0] ST_STORED    = 4'd0;
  localparam logic [3:0] ST_DUP       = 4'd1;
  localparam logic [3:0] ST_OLD       = 4'd2;
  localparam logic [3:0] ST_BEYOND    = 4'd3;
  localparam logic [3:0] ST_PURE_ACK  = 4'd4;
  localparam logic [3:0] ST_DELIVERED = 4'd5;
  localparam logic [3:0] ST_NOT_READY = 4'd6;
  localparam logic [3:0] ST_ACK_BUILT = 4'd7;
  localparam logic [3:0] ST_DROPPED   = 4'd8;

  localparam logic [8:0] CAP_FIRST = 9'd511;
  localparam logic [8:0] CAP_REST  = 9'd255;

  typedef enum logic [4:0] {
    K_MSG  = 5'b00001,
    K_PURE = 5'b00010,
    K_DLV  = 5'b00100,
    K_ACK  = 5'b01000,
    K_DROP = 5'b10000
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] id;
  } q_entry_t;

endpackage
`default_nettype wire

FILE: design/rwsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rwsb_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/rwsb_front.sv
// Front end: accepts input transactions, classifies them, and queues them
// in a two-entry FIFO for the back end. Depends on rwsb_pkg.
`default_nettype none
module rwsb_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [63:0]        msg_id,
  input  wire logic               carries_data,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output rwsb_pkg::q_entry_t      q_entry
);

  rwsb_pkg::q_entry_t ent [2];
  rwsb_pkg::q_entry_t cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    cls.id = msg_id;
    case (op)
      rwsb_pkg::OP_MSG: cls.kind = carries_data ? rwsb_pkg::K_MSG : rwsb_pkg::K_PURE;
      rwsb_pkg::OP_DLV: cls.kind = rwsb_pkg::K_DLV;
      rwsb_pkg::OP_ACK: cls.kind = rwsb_pkg::K_ACK;
      default:          cls.kind = rwsb_pkg::K_DROP;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_entry  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/rwsb_back.sv
// Back end: sequencer that executes queued transactions against the slot
// flag RAM and the window registers. Depends on rwsb_pkg and rwsb_ram.
`default_nettype none
module rwsb_back #(
  parameter int WINDOW_SLOTS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire rwsb_pkg::q_entry_t  q_entry,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [3:0]               status,
  output logic [63:0]              position,
  output logic [8:0]               gap_one,
  output logic [8:0]               run_one,
  output logic [7:0]               gap_two,
  output logic [7:0]               run_two,
  output logic [7:0]               gap_three,
  output logic [7:0]               run_three,
  output logic [7:0]               gap_four,
  output logic [7:0]               run_four,
  output logic [7:0]               gap_five,
  output logic [7:0]               run_five
);

  localparam int SW = $clog2(WINDOW_SLOTS);
  localparam int RW = SW + 1;
  localparam logic [RW-1:0] WIN  = RW'(WINDOW_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(WINDOW_SLOTS - 1);
  localparam logic [3:0]    PH_LAST = 4'd10;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_MCHK  = 13'b0000000000100,
    S_MWAIT = 13'b0000000001000,
    S_MEV   = 13'b0000000010000,
    S_DCHK  = 13'b0000000100000,
    S_DWAIT = 13'b0000001000000,
    S_DEV   = 13'b0000010000000,
    S_DROP  = 13'b0000100000000,
    S_ACHK  = 13'b0001000000000,
    S_AWAIT = 13'b0010000000000,
    S_AEV   = 13'b0100000000000,
    S_ADONE = 13'b1000000000000
  } state_t;

  state_t        state;
  logic [63:0]   written_id;
  logic [63:0]   highest_id;
  logic [SW-1:0] written_slot;
  logic [SW-1:0] highest_slot;
  logic [63:0]   cur_id;
  logic [SW-1:0] addr;
  logic [SW-1:0] cur_slot;
  logic [RW-1:0] rel;
  logic [RW-1:0] end_rel;
  logic [RW-1:0] stop0;
  logic [8:0]    cnt;
  logic [3:0]    ph;
  logic          brk;
  logic [8:0]    gap [5];
  logic [8:0]    run [5];
  logic [3:0]    status_r;
  logic [63:0]   pos_r;

  logic          mem_we;
  logic [1:0]    mem_wdata;
  logic [1:0]    rdata;

  // flag bit 1: received, bit 0: acknowledged
  rwsb_ram #(.WIDTH(2), .DEPTH(WINDOW_SLOTS)) u_flags (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == LAST) ? '0 : s + 1'b1;
  endfunction

  logic [63:0]   diff;
  logic [RW-1:0] slot_sum;
  logic [63:0]   span;
  logic          is_gap;
  logic          capped;
  logic          scan_stop;
  logic [2:0]    pair;

  assign diff     = cur_id - written_id;
  assign slot_sum = {1'b0, written_slot} + diff[RW-1:0];
  assign span     = highest_id - written_id;
  assign is_gap   = ph[0];
  assign pair     = ph[3:1];
  assign capped   = (ph != 4'd0) && (cnt >= ((ph <= 4'd2) ? rwsb_pkg::CAP_FIRST
                                                          : rwsb_pkg::CAP_REST));
  assign scan_stop = is_gap ? (rdata[1] && !rdata[0]) : !rdata[1];

  assign q_pop = (state == S_IDLE) && q_valid && !out_valid;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 2'b00;
    case (state)
      S_CLR:  mem_we = 1'b1;
      S_DROP: mem_we = 1'b1;
      S_MEV: begin
        mem_we    = 1'b1;
        mem_wdata = 2'b10;
      end
      S_DEV:  mem_we = rdata[1];
      S_AEV: begin
        mem_we    = !is_gap && rdata[1];
        mem_wdata = 2'b11;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      addr         <= '0;
      written_id   <= '0;
      highest_id   <= '0;
      written_slot <= '0;
      highest_slot <= '0;
      out_valid    <= 1'b0;
      brk          <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          if (addr == LAST) state <= S_IDLE;
          else addr <= addr + 1'b1;
        end
        S_IDLE: begin
          if (q_pop) begin
            cur_id <= q_entry.id;
            pos_r  <= '0;
            for (int i = 0; i < 5; i++) begin
              gap[i] <= '0;
              run[i] <= '0;
            end
            case (q_entry.kind)
              rwsb_pkg::K_PURE: begin
                status_r  <= rwsb_pkg::ST_PURE_ACK;
                out_valid <= 1'b1;
              end
              rwsb_pkg::K_MSG: state <= S_MCHK;
              rwsb_pkg::K_DLV: state <= S_DCHK;
              rwsb_pkg::K_ACK: begin
                rel      <= '0;
                end_rel  <= span[RW-1:0];
                cur_slot <= written_slot;
                cnt      <= '0;
                ph       <= '0;
                brk      <= 1'b0;
                state    <= S_ACHK;
              end
              default: begin
                if (written_id != highest_id) begin
                  addr    <= slot_inc(written_slot);
                  rel     <= RW'(1);
                  end_rel <= span[RW-1:0];
                  state   <= S_DROP;
                end else begin
                  status_r  <= rwsb_pkg::ST_DROPPED;
                  out_valid <= 1'b1;
                end
              end
            endcase
          end
        end
        S_MCHK: begin
          if (cur_id <= written_id) begin
            status_r  <= rwsb_pkg::ST_OLD;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (diff > {{(64-RW){1'b0}}, WIN}) begin
            status_r  <= rwsb_pkg::ST_BEYOND;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            addr  <= (slot_sum >= WIN) ? SW'(slot_sum - WIN) : slot_sum[SW-1:0];
            state <= S_MWAIT;
          end
        end
        S_MWAIT: state <= S_MEV;
        S_MEV: begin
          status_r <= rdata[1] ? rwsb_pkg::ST_DUP : rwsb_pkg::ST_STORED;
          if (!rdata[1] && cur_id > highest_id) begin
            highest_id   <= cur_id;
            highest_slot <= addr;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_DCHK: begin
          if (written_id < highest_id) begin
            addr  <= slot_inc(written_slot);
            state <= S_DWAIT;
          end else begin
            status_r  <= rwsb_pkg::ST_NOT_READY;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DWAIT: state <= S_DEV;
        S_DEV: begin
          if (rdata[1]) begin
            written_id   <= written_id + 64'd1;
            written_slot <= addr;
            pos_r        <= written_id + 64'd1;
            status_r     <= rwsb_pkg::ST_DELIVERED;
          end else begin
            status_r <= rwsb_pkg::ST_NOT_READY;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_DROP: begin
          if (rel == end_rel) begin
            written_id   <= highest_id;
            written_slot <= highest_slot;
            status_r     <= rwsb_pkg::ST_DROPPED;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            rel  <= rel + 1'b1;
            addr <= slot_inc(addr);
          end
        end
        S_ACHK: begin
          if (rel < end_rel && !capped && !brk) begin
            addr  <= slot_inc(cur_slot);
            state <= S_AWAIT;
          end else begin
            // close the current scan phase and record its length
            if (ph == 4'd0) stop0 <= rel;
            else if (is_gap) gap[pair] <= cnt;
            else run[pair - 3'd1] <= cnt;
            cnt <= '0;
            brk <= 1'b0;
            if (ph == PH_LAST) state <= S_ADONE;
            else ph <= ph + 4'd1;
          end
        end
        S_AWAIT: state <= S_AEV;
        S_AEV: begin
          if (scan_stop) begin
            brk <= 1'b1;
          end else begin
            rel      <= rel + 1'b1;
            cnt      <= cnt + 9'd1;
            cur_slot <= addr;
          end
          state <= S_ACHK;
        end
        S_ADONE: begin
          pos_r     <= written_id + {{(64-RW){1'b0}}, stop0};
          status_r  <= rwsb_pkg::ST_ACK_BUILT;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status    = status_r;
  assign position  = pos_r;
  assign gap_one   = gap[0];
  assign run_one   = run[0];
  assign gap_two   = gap[1][7:0];
  assign run_two   = run[1][7:0];
  assign gap_three = gap[2][7:0];
  assign run_three = run[2][7:0];
  assign gap_four  = gap[3][7:0];
  assign run_four  = run[3][7:0];
  assign gap_five  = gap[4][7:0];
  assign run_five  = run[4][7:0];

endmodule
`default_nettype wire

FILE: design/reorder_window_sack_builder_top.sv
// Reorder window with SACK builder; one transaction in the back end at a time,
// the next is popped the cycle after its result is taken. A drop walks the pending
// slots; an ack build reads each slot walked plus one ending each scan phase.
// Sync reset, then a clearing pass over every slot; the input queue still takes
// two transactions meanwhile.
`default_nettype none
module reorder_window_sack_builder_top #(
  parameter int WINDOW_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [63:0] msg_id,
  input  wire logic        carries_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [63:0]      position,
  output logic [8:0]       gap_one,
  output logic [8:0]       run_one,
  output logic [7:0]       gap_two,
  output logic [7:0]       run_two,
  output logic [7:0]       gap_three,
  output logic [7:0]       run_three,
  output logic [7:0]       gap_four,
  output logic [7:0]       run_four,
  output logic [7:0]       gap_five,
  output logic [7:0]       run_five
);

  logic               q_valid;
  logic               q_pop;
  rwsb_pkg::q_entry_t q_entry;

  rwsb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .msg_id       (msg_id),
    .carries_data (carries_data),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_entry      (q_entry)
  );

  rwsb_back #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .gap_one   (gap_one),
    .run_one   (run_one),
    .gap_two   (gap_two),
    .run_two   (run_two),
    .gap_three (gap_three),
    .run_three (run_three),
    .gap_four  (gap_four),
    .run_four  (run_four),
    .gap_five  (gap_five),
    .run_five  (run_five)
  );

endmodule
`default_nettype wire

FILE: test/reorder_window_sack_builder_top_tb.sv
// Self-checking testbench for reorder_window_sack_builder_top. Needs rwsb_pkg
// for op and status codes; a directed table runs first, then random traffic.
// Typed rows are checked against the table, the rest against an in-bench model.
`default_nettype none
module reorder_window_sack_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 256;
  localparam int SW = $clog2(WIN);
  localparam int RANDOM_ITEMS = 1830;

  typedef struct {
    logic [3:0]       status;
    logic [63:0]      position;
    logic [4:0][8:0]  gaps;
    logic [4:0][8:0]  runs;
  } sack_t;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] id;
    logic        data;
    bit          typed;
    logic [3:0]  status;
    logic [63:0] position;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = rwsb_pkg::OP_MSG;
  logic [63:0] msg_id = '0;
  logic carries_data = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] status;
  logic [63:0] position;
  logic [8:0] gap_one, run_one;
  logic [7:0] gap_two, run_two, gap_three, run_three;
  logic [7:0] gap_four, run_four, gap_five, run_five;

  // window model state
  logic [63:0] last_delivered;
  logic [63:0] top_seen;
  bit held[WIN];
  bit reported[WIN];

  sack_t due_reports[$];
  int errors = 0;
  bit quiet = 0;
  int stall_left = 0;

  always #2 clk = ~clk;

  reorder_window_sack_builder_top DUT (.*);

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [SW-1:0] slot_of(logic [63:0] id);
    return SW'(id % WIN);
  endfunction

  function automatic logic [63:0] skip_gap(logic [63:0] from, logic [63:0] upto, int cap);
    logic [63:0] at;
    int n;
    at = from;
    n = 0;
    while (at < upto && n < cap) begin
      if (held[slot_of(at + 64'd1)] && !reported[slot_of(at + 64'd1)]) break;
      at++;
      n++;
    end
    return at;
  endfunction

  // walks a held run and marks it acknowledged
  function automatic logic [63:0] take_run(logic [63:0] from, logic [63:0] upto, int cap);
    logic [63:0] at;
    int n;
    at = from;
    n = 0;
    while (at < upto && n < cap) begin
      if (!held[slot_of(at + 64'd1)]) break;
      reported[slot_of(at + 64'd1)] = 1'b1;
      at++;
      n++;
    end
    return at;
  endfunction

  function automatic sack_t window_step(logic [1:0] o, logic [63:0] id, logic d);
    sack_t r;
    logic [63:0] stop, start, n;
    int cap;
    r = '{default: '0};
    case (o)
      rwsb_pkg::OP_MSG: begin
        if (!d) r.status = rwsb_pkg::ST_PURE_ACK;
        else if (id <= last_delivered) r.status = rwsb_pkg::ST_OLD;
        else if (id - last_delivered > 64'(WIN)) r.status = rwsb_pkg::ST_BEYOND;
        else begin
          if (!held[slot_of(id)]) begin
            held[slot_of(id)] = 1'b1;
            if (id > top_seen) top_seen = id;
            r.status = rwsb_pkg::ST_STORED;
          end else begin
            r.status = rwsb_pkg::ST_DUP;
          end
          reported[slot_of(id)] = 1'b0;
        end
      end
      rwsb_pkg::OP_DLV: begin
        if (last_delivered < top_seen && held[slot_of(last_delivered + 64'd1)]) begin
          held[slot_of(last_delivered + 64'd1)] = 1'b0;
          reported[slot_of(last_delivered + 64'd1)] = 1'b0;
          last_delivered++;
          r.status = rwsb_pkg::ST_DELIVERED;
          r.position = last_delivered;
        end else begin
          r.status = rwsb_pkg::ST_NOT_READY;
        end
      end
      rwsb_pkg::OP_ACK: begin
        stop = take_run(last_delivered, top_seen, WIN + 1);
        r.status = rwsb_pkg::ST_ACK_BUILT;
        r.position = stop;
        for (int k = 0; k < 5; k++) begin
          cap = (k == 0) ? int'(rwsb_pkg::CAP_FIRST) : int'(rwsb_pkg::CAP_REST);
          start = skip_gap(stop, top_seen, cap);
          r.gaps[k] = 9'(start - stop);
          stop = take_run(start, top_seen, cap);
          r.runs[k] = 9'(stop - start);
        end
      end
      default: begin
        if (last_delivered != top_seen) begin
          n = top_seen - last_delivered;
          if (n > 64'(WIN)) n = 64'(WIN);
          for (logic [63:0] i = 64'd1; i <= n; i++) begin
            held[slot_of(last_delivered + i)] = 1'b0;
            reported[slot_of(last_delivered + i)] = 1'b0;
          end
          last_delivered = top_seen;
        end
        r.status = rwsb_pkg::ST_DROPPED;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(input logic [1:0] o, input logic [63:0] id, input logic d,
                      input sack_t want);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    msg_id <= id;
    carries_data <= d;
    due_reports.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side: check and drive stall
  always @(posedge clk) begin
    sack_t w;
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected transaction status", 64'(status), 64'd0);
      end else begin
        w = due_reports.pop_front();
        if (status !== w.status)
          report_mismatch("status", 64'(status), 64'(w.status));
        if (position !== w.position)
          report_mismatch("position", position, w.position);
        if (gap_one !== w.gaps[0])
          report_mismatch("gap_one", 64'(gap_one), 64'(w.gaps[0]));
        if (run_one !== w.runs[0])
          report_mismatch("run_one", 64'(run_one), 64'(w.runs[0]));
        if (gap_two !== w.gaps[1][7:0])
          report_mismatch("gap_two", 64'(gap_two), 64'(w.gaps[1]));
        if (run_two !== w.runs[1][7:0])
          report_mismatch("run_two", 64'(run_two), 64'(w.runs[1]));
        if (gap_three !== w.gaps[2][7:0])
          report_mismatch("gap_three", 64'(gap_three), 64'(w.gaps[2]));
        if (run_three !== w.runs[2][7:0])
          report_mismatch("run_three", 64'(run_three), 64'(w.runs[2]));
        if (gap_four !== w.gaps[3][7:0])
          report_mismatch("gap_four", 64'(gap_four), 64'(w.gaps[3]));
        if (run_four !== w.runs[3][7:0])
          report_mismatch("run_four", 64'(run_four), 64'(w.runs[3]));
        if (gap_five !== w.gaps[4][7:0])
          report_mismatch("gap_five", 64'(gap_five), 64'(w.gaps[4]));
        if (run_five !== w.runs[4][7:0])
          report_mismatch("run_five", 64'(run_five), 64'(w.runs[4]));
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
    end
  end

  initial begin
    #40ms;
    $display("reorder_window_sack_builder_top_tb NOT OK");
    $finish;
  end

  initial begin
    row_t dir[24];
    sack_t want, fixed;
    logic [1:0] o;
    logic [63:0] id;
    logic d;
    int r;

    last_delivered = '0;
    top_seen = '0;
    foreach (held[i]) begin
      held[i] = 1'b0;
      reported[i] = 1'b0;
    end

    dir = '{
      '{rwsb_pkg::OP_DLV,  64'd0, 1'b1, 1, rwsb_pkg::ST_NOT_READY, 64'd0},
      '{rwsb_pkg::OP_ACK,  64'd0, 1'b1, 1, rwsb_pkg::ST_ACK_BUILT, 64'd0},
      '{rwsb_pkg::OP_DROP, 64'd0, 1'b1, 1, rwsb_pkg::ST_DROPPED, 64'd0},
      '{rwsb_pkg::OP_MSG,  '1,    1'b0, 1, rwsb_pkg::ST_PURE_ACK, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd0, 1'b1, 1, rwsb_pkg::ST_OLD, 64'd0},
      '{rwsb_pkg::OP_MSG,  '1,    1'b1, 1, rwsb_pkg::ST_BEYOND, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd257, 1'b1, 1, rwsb_pkg::ST_BEYOND, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd256, 1'b1, 1, rwsb_pkg::ST_STORED, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd1, 1'b1, 1, rwsb_pkg::ST_STORED, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd1, 1'b1, 1, rwsb_pkg::ST_DUP, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd4, 1'b1, 1, rwsb_pkg::ST_STORED, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd6, 1'b1, 1, rwsb_pkg::ST_STORED, 64'd0},
      '{rwsb_pkg::OP_ACK,  64'd0, 1'b1, 0, rwsb_pkg::ST_ACK_BUILT, 64'd0},
      '{rwsb_pkg::OP_ACK,  64'd0, 1'b1, 0, rwsb_pkg::ST_ACK_BUILT, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd4, 1'b1, 1, rwsb_pkg::ST_DUP, 64'd0},
      '{rwsb_pkg::OP_ACK,  64'd0, 1'b1, 0, rwsb_pkg::ST_ACK_BUILT, 64'd0},
      '{rwsb_pkg::OP_DLV,  64'd0, 1'b1, 1, rwsb_pkg::ST_DELIVERED, 64'd1},
      '{rwsb_pkg::OP_DLV,  64'd0, 1'b1, 1, rwsb_pkg::ST_NOT_READY, 64'd0},
      '{rwsb_pkg::OP_DROP, 64'd0, 1'b1, 1, rwsb_pkg::ST_DROPPED, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd256, 1'b1, 1, rwsb_pkg::ST_OLD, 64'd0},
      '{rwsb_pkg::OP_MSG,  64'd512, 1'b1, 1, rwsb_pkg::ST_STORED, 64'd0},
      '{rwsb_pkg::OP_DLV,  64'd0, 1'b1, 1, rwsb_pkg::ST_NOT_READY, 64'd0},
      '{rwsb_pkg::OP_ACK,  64'd0, 1'b1, 0, rwsb_pkg::ST_ACK_BUILT, 64'd0},
      '{rwsb_pkg::OP_DROP, 64'd0, 1'b1, 1, rwsb_pkg::ST_DROPPED, 64'd0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir[i]) begin
      want = window_step(dir[i].op, dir[i].id, dir[i].data);
      if (dir[i].typed) begin
        fixed = '{default: '0};
        fixed.status = dir[i].status;
        fixed.position = dir[i].position;
        want = fixed;
      end
      send(dir[i].op, dir[i].id, dir[i].data, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 300 && n < 420);
      if (n == 900) begin
        // hold off until the block has drained
        in_valid <= 1'b0;
        wait (due_reports.size() == 0);
        @(posedge clk);
      end
      r = $urandom_range(99);
      d = 1'b1;
      id = {$urandom, $urandom};
      if (r < 52) begin
        o = rwsb_pkg::OP_MSG;
        d = ($urandom_range(9) != 0);
        r = $urandom_range(99);
        if (r < 72) id = last_delivered + 64'($urandom_range(1, WIN));
        else if (r < 80) id = last_delivered + 64'($urandom_range(WIN + 1, WIN + 40));
        else if (r < 90) id = last_delivered - 64'($urandom_range(0, 40));
      end else if (r < 78) begin
        o = rwsb_pkg::OP_DLV;
      end else if (r < 94) begin
        o = rwsb_pkg::OP_ACK;
      end else begin
        o = rwsb_pkg::OP_DROP;
      end
      want = window_step(o, id, d);
      send(o, id, d, want);
    end
    in_valid <= 1'b0;

    wait (due_reports.size() == 0);
    repeat (900) @(posedge clk);
    if (errors == 0) begin
      $display("reorder_window_sack_builder_top_tb OK");
    end else begin
      $display("reorder_window_sack_builder_top_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
